>>> rtl/rqsjf_pkg.sv
// package: shared types and constants of the job ready queue
`default_nettype none
package rqsjf_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_W            = 8;
  localparam int DUR_W           = 16;
  localparam int POLICY_W        = 2;

  localparam logic [POLICY_W-1:0] POLICY_FCFS  = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_SJF   = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_AGING = 2'd2;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [ID_W-1:0]  job_id;
    logic [DUR_W-1:0] job_duration;
    logic             job_started;
  } job_t;

  typedef struct packed {
    logic             out_valid;
    logic [ID_W-1:0]  out_job_id;
    logic [DUR_W-1:0] out_duration;
    logic             overflow;
    logic             now_empty;
  } result_t;

  typedef struct packed {
    logic             enq;
    logic             deq;
    logic             fcfs;
    logic             front;
    logic             aging;
    logic [ID_W-1:0]  new_id;
    logic [DUR_W-1:0] new_dur;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/rqsjf_cell.sv
// one queue slot: holds a job and shifts with its neighbors
`default_nettype none
module rqsjf_cell
  import rqsjf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int INDEX       = 0,
  localparam int OCC_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [OCC_W-1:0] occ,
  input  wire logic             ge_in,
  output logic                  ge_out,
  input  wire logic [ID_W-1:0]  left_id,
  input  wire logic [DUR_W-1:0] left_dur,
  input  wire logic [ID_W-1:0]  right_id,
  input  wire logic [DUR_W-1:0] right_dur,
  output logic [ID_W-1:0]       slot_id,
  output logic [DUR_W-1:0]      slot_dur
);

  logic occupied;
  logic at_tail;
  logic hit;
  logic dec;

  always_comb begin
    occupied = OCC_W'(INDEX) < occ;
    at_tail  = OCC_W'(INDEX) == occ;
    if (ctrl.fcfs) begin
      hit = at_tail;
    end else if (ctrl.front) begin
      hit = (INDEX == 0);
    end else begin
      hit = (occupied && (slot_dur > ctrl.new_dur)) || at_tail;
    end
    ge_out = ge_in | hit;
    dec    = ctrl.aging && (right_dur != '0);
  end

  always_ff @(posedge clk) begin
    if (ctrl.enq) begin
      if (hit && !ge_in) begin
        slot_id  <= ctrl.new_id;
        slot_dur <= ctrl.new_dur;
      end else if (ge_in) begin
        slot_id  <= left_id;
        slot_dur <= left_dur;
      end
    end else if (ctrl.deq) begin
      slot_id  <= right_id;
      slot_dur <= right_dur - DUR_W'(dec);
    end
  end

endmodule
`default_nettype wire

>>> rtl/ready_queue_sjf_aging.sv
// top level: job ready queue with fcfs, sjf and aging policies
//
// usage: a job transaction (job_valid, job_stall, job) either enqueues a job
// or dequeues the head. every accepted job transaction produces exactly one
// result transaction (res_valid, res_stall, res), in order.
// latency: the result is registered and appears the cycle after acceptance.
// throughput: one transaction per cycle while job_stall is low; all slots
// shift at once, the insert position found by a compare in every slot and a
// prefix chain from head to tail. the user must write the policy register
// through cfg_we / cfg_data only while idle; the block does not enforce it.
// reset (rst, synchronous) empties the queue, clears the result valid flag
// and sets the policy to first come first served.
// while a result waits and res_stall is high, job_stall is raised and no
// new job transaction is taken; the held result does not change.
`default_nettype none
module ready_queue_sjf_aging
  import rqsjf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [POLICY_W-1:0] cfg_data,
  input  wire logic                job_valid,
  output logic                     job_stall,
  input  wire job_t                job,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output result_t                  res
);

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  logic [POLICY_W-1:0] policy;
  logic [OCC_W-1:0]    occ;
  logic [OCC_W-1:0]    occ_next;
  logic                accept;
  logic                full;
  logic                empty;
  cell_ctrl_t          ctrl;
  result_t             res_next;

  logic [ID_W-1:0]  cell_id  [QUEUE_DEPTH];
  logic [DUR_W-1:0] cell_dur [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] ge;

  assign job_stall = res_valid && res_stall;
  assign accept    = job_valid && !job_stall;
  assign full      = (occ == OCC_W'(QUEUE_DEPTH));
  assign empty     = (occ == '0);

  always_comb begin
    ctrl.enq     = accept && (job.mode == MODE_ENQ) && !full;
    ctrl.deq     = accept && (job.mode == MODE_DEQ) && !empty;
    ctrl.fcfs    = (policy == POLICY_FCFS);
    ctrl.aging   = policy[1];
    ctrl.front   = policy[1] && !empty && job.job_started && (cell_dur[0] == job.job_duration);
    ctrl.new_id  = job.job_id;
    ctrl.new_dur = job.job_duration;
  end

  always_comb begin
    occ_next = occ;
    if (ctrl.enq) begin
      occ_next = occ + OCC_W'(1);
    end else if (ctrl.deq) begin
      occ_next = occ - OCC_W'(1);
    end
  end

  always_comb begin
    res_next.out_valid    = ctrl.deq;
    res_next.out_job_id   = ctrl.deq ? cell_id[0] : '0;
    res_next.out_duration = ctrl.deq ? cell_dur[0] : '0;
    res_next.overflow     = accept && (job.mode == MODE_ENQ) && full;
    res_next.now_empty    = (occ_next == '0);
  end

  assign ge[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_W-1:0]  l_id;
    logic [DUR_W-1:0] l_dur;
    logic [ID_W-1:0]  r_id;
    logic [DUR_W-1:0] r_dur;
    if (i == 0) begin : g_head
      assign l_id  = job.job_id;
      assign l_dur = job.job_duration;
    end else begin : g_body
      assign l_id  = cell_id[i-1];
      assign l_dur = cell_dur[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_id  = cell_id[i];
      assign r_dur = cell_dur[i];
    end else begin : g_inner
      assign r_id  = cell_id[i+1];
      assign r_dur = cell_dur[i+1];
    end
    rqsjf_cell #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .INDEX      (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occ      (occ),
      .ge_in    (ge[i]),
      .ge_out   (ge[i+1]),
      .left_id  (l_id),
      .left_dur (l_dur),
      .right_id (r_id),
      .right_dur(r_dur),
      .slot_id  (cell_id[i]),
      .slot_dur (cell_dur[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy    <= POLICY_FCFS;
      occ       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        policy <= cfg_data;
      end
      occ <= occ_next;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy above depth");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.enq |=> occ == $past(occ) + OCC_W'(1))
    else $error("enqueue did not grow the queue");

  a_slot_found: assert property (@(posedge clk) disable iff (rst)
    ctrl.enq |-> ge[QUEUE_DEPTH])
    else $error("enqueue found no insert slot");

  a_empty_deq: assert property (@(posedge clk) disable iff (rst)
    accept && (job.mode == MODE_DEQ) && empty |=>
      res_valid && !res.out_valid && res.now_empty)
    else $error("dequeue from empty queue misreported");

  a_ovf_no_job: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.overflow |-> !res.out_valid && !res.now_empty)
    else $error("overflow result carries a job");

endmodule
`default_nettype wire

>>> tb/sv/ready_queue_checker.sv
// checker: predicts the ready queue from observed transactions and compares its results
`timescale 1ns / 1ps
module ready_queue_checker
  import rqsjf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [POLICY_W-1:0] cfg_data,
  input  logic                job_valid,
  input  logic                job_stall,
  input  job_t                job,
  input  logic                res_valid,
  input  logic                res_stall,
  input  result_t             res,
  output int                  mismatch_count,
  output int                  results_due,
  output int                  jobs_seen,
  output int                  jobs_dequeued,
  output int                  jobs_dropped,
  output int                  front_pushes
);

  localparam int DEPTH = QUEUE_DEPTH_DEF;

  logic [ID_W-1:0]     held_id  [DEPTH];
  logic [DUR_W-1:0]    held_dur [DEPTH];
  int                  fill;
  logic [POLICY_W-1:0] policy_q;
  result_t             expected_results [$];
  result_t             want;

  initial begin
    mismatch_count = 0;
    results_due    = 0;
    jobs_seen      = 0;
    jobs_dequeued  = 0;
    jobs_dropped   = 0;
    front_pushes   = 0;
    fill           = 0;
    policy_q       = POLICY_FCFS;
  end

  function automatic result_t place_job(input job_t j);
    result_t r;
    int      pos;
    logic    aging;
    r     = '0;
    aging = policy_q[1];
    if (j.mode == MODE_ENQ) begin
      if (fill >= DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        pos = fill;
        if (policy_q == POLICY_FCFS) begin
          pos = fill;
        end else if (aging && fill > 0 && j.job_started && held_dur[0] == j.job_duration) begin
          pos = 0;
          front_pushes++;
        end else begin
          for (int i = fill - 1; i >= 0; i--)
            if (held_dur[i] > j.job_duration) pos = i;
        end
        for (int i = fill; i > pos; i--) begin
          held_id[i]  = held_id[i-1];
          held_dur[i] = held_dur[i-1];
        end
        held_id[pos]  = j.job_id;
        held_dur[pos] = j.job_duration;
        fill++;
      end
    end else if (fill > 0) begin
      r.out_valid    = 1'b1;
      r.out_job_id   = held_id[0];
      r.out_duration = held_dur[0];
      for (int i = 1; i < fill; i++) begin
        held_id[i-1]  = held_id[i];
        held_dur[i-1] = held_dur[i];
      end
      fill--;
      if (aging) begin
        for (int i = 0; i < fill; i++)
          if (held_dur[i] != '0) held_dur[i] = held_dur[i] - 1'b1;
      end
    end
    r.now_empty = (fill == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill     = 0;
      policy_q = POLICY_FCFS;
      expected_results.delete();
    end else begin
      if (cfg_we) policy_q = cfg_data;
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result transaction with none expected: %p", $realtime, res);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (res.out_valid !== want.out_valid || res.out_job_id !== want.out_job_id ||
              res.out_duration !== want.out_duration || res.overflow !== want.overflow ||
              res.now_empty !== want.now_empty) begin
            if (mismatch_count < 10) begin
              $display("%0t: result differs: expected valid=%b id=%h dur=%h ovf=%b empty=%b",
                       $realtime, want.out_valid, want.out_job_id, want.out_duration,
                       want.overflow, want.now_empty);
              $display("%0t:                 got      valid=%b id=%h dur=%h ovf=%b empty=%b",
                       $realtime, res.out_valid, res.out_job_id, res.out_duration,
                       res.overflow, res.now_empty);
            end
            mismatch_count++;
          end
          if (want.out_valid) jobs_dequeued++;
          if (want.overflow) jobs_dropped++;
        end
      end
      if (job_valid && !job_stall) begin
        expected_results.push_back(place_job(job));
        jobs_seen++;
      end
    end
    results_due = expected_results.size();
  end

endmodule

>>> tb/sv/ready_queue_sjf_aging_tb.sv
// testbench top: stimulus, stall pattern and verdict for the job ready queue
`timescale 1ns / 1ps
module ready_queue_sjf_aging_tb;
  import rqsjf_pkg::*;

  localparam logic [POLICY_W-1:0] POLICY_AGING_ALT = 2'd3;
  localparam int PHASES           = 8;
  localparam int ITEMS_PER_PHASE  = 141;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int HOLD_PHASE       = 1;
  localparam int TIMEOUT_NS       = 2_000_000;

  localparam logic [POLICY_W-1:0] PHASE_POLICY [PHASES] = '{
    POLICY_SJF, POLICY_AGING, POLICY_AGING_ALT, POLICY_FCFS,
    POLICY_AGING, POLICY_SJF, POLICY_AGING_ALT, POLICY_AGING
  };

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [POLICY_W-1:0] cfg_data  = POLICY_FCFS;
  logic                job_valid = 1'b0;
  logic                job_stall;
  job_t                job       = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  result_t             res;

  int   mismatch_count, results_due, jobs_seen, jobs_dequeued, jobs_dropped, front_pushes;
  logic gaps_on       = 1'b1;
  logic stalls_on     = 1'b1;
  logic long_hold_req = 1'b0;

  always #5 clk = ~clk;

  ready_queue_sjf_aging dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  ready_queue_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .job_valid      (job_valid),
    .job_stall      (job_stall),
    .job            (job),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .res            (res),
    .mismatch_count (mismatch_count),
    .results_due    (results_due),
    .jobs_seen      (jobs_seen),
    .jobs_dequeued  (jobs_dequeued),
    .jobs_dropped   (jobs_dropped),
    .front_pushes   (front_pushes)
  );

  function automatic job_t make_job(input logic mode, input logic [ID_W-1:0] id,
                                    input logic [DUR_W-1:0] dur, input logic started);
    job_t j;
    j.mode         = mode;
    j.job_id       = id;
    j.job_duration = dur;
    j.job_started  = started;
    return j;
  endfunction

  function automatic job_t random_job(input int enq_pct);
    job_t j;
    int   pick;
    j.mode        = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
    j.job_id      = ID_W'($urandom_range(0, 255));
    j.job_started = 1'($urandom_range(0, 1));
    pick          = $urandom_range(0, 9);
    if (pick < 6)       j.job_duration = DUR_W'($urandom_range(0, 7));
    else if (pick == 6) j.job_duration = '0;
    else if (pick == 7) j.job_duration = '1;
    else                j.job_duration = DUR_W'($urandom_range(0, 65535));
    return j;
  endfunction

  // drive at the falling edge, hold until taken, return at the next falling edge
  task automatic send_job(input job_t j);
    job       <= j;
    job_valid <= 1'b1;
    @(posedge clk);
    while (job_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      job_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  // only while idle: all results in, then a short pause for the result register
  task automatic write_policy(input logic [POLICY_W-1:0] p);
    job_valid <= 1'b0;
    wait (results_due == 0);
    @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= p;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // receiver stall pattern
  initial begin
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end else if (stalls_on && $urandom_range(0, 2) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        res_stall <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int enq_pct;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fcfs: empty dequeue, field extremes, arrival order
    write_policy(POLICY_FCFS);
    send_job(make_job(MODE_DEQ, 8'hFF, 16'hFFFF, 1'b1));
    send_job(make_job(MODE_ENQ, 8'h00, 16'h0000, 1'b0));
    send_job(make_job(MODE_ENQ, 8'hFF, 16'hFFFF, 1'b1));
    send_job(make_job(MODE_DEQ, 8'h00, 16'h0000, 1'b0));
    send_job(make_job(MODE_DEQ, 8'h00, 16'h0000, 1'b0));
    send_job(make_job(MODE_DEQ, 8'h00, 16'h0000, 1'b0));

    // sjf: shortest first, ties keep arrival order
    write_policy(POLICY_SJF);
    send_job(make_job(MODE_ENQ, 8'h01, 16'd5, 1'b0));
    send_job(make_job(MODE_ENQ, 8'h02, 16'd3, 1'b1));
    send_job(make_job(MODE_ENQ, 8'h03, 16'd5, 1'b0));
    send_job(make_job(MODE_ENQ, 8'h04, 16'd1, 1'b0));
    repeat (4) send_job(make_job(MODE_DEQ, 8'h00, 16'h0000, 1'b0));

    // aging: started job into empty queue, front push on equal head, saturation at zero
    write_policy(POLICY_AGING);
    send_job(make_job(MODE_ENQ, 8'h0A, 16'd7, 1'b1));
    send_job(make_job(MODE_ENQ, 8'h0B, 16'd7, 1'b1));
    send_job(make_job(MODE_ENQ, 8'h0C, 16'd0, 1'b0));
    send_job(make_job(MODE_ENQ, 8'h0F, 16'd0, 1'b1));
    send_job(make_job(MODE_ENQ, 8'h0D, 16'd7, 1'b1));
    send_job(make_job(MODE_DEQ, 8'h00, 16'h0000, 1'b0));
    send_job(make_job(MODE_DEQ, 8'h00, 16'h0000, 1'b0));
    send_job(make_job(MODE_ENQ, 8'h0E, 16'd5, 1'b0));
    send_job(make_job(MODE_DEQ, 8'h00, 16'h0000, 1'b0));
    send_job(make_job(MODE_DEQ, 8'h00, 16'h0000, 1'b0));

    for (int ph = 0; ph < PHASES; ph++) begin
      write_policy(PHASE_POLICY[ph]);
      if (ph == PHASES - 1) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      enq_pct = 50;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 20 == 0) begin
          case ($urandom_range(0, 2))
            0:       enq_pct = 85;
            1:       enq_pct = 50;
            default: enq_pct = 15;
          endcase
        end
        if (ph == HOLD_PHASE && n == 30) long_hold_req = 1'b1;
        send_job(random_job(enq_pct));
        if (!(ph == HOLD_PHASE && n >= 30 && n < 60)) sender_gap();
      end
    end

    job_valid <= 1'b0;
    wait (results_due == 0);
    repeat (4) @(negedge clk);
    $display("ran %0d job transactions over fcfs, sjf and both aging codes with a long result hold",
             jobs_seen);
    $display("  %0d jobs dequeued, %0d dropped on a full queue, %0d aging front pushes",
             jobs_dequeued, jobs_dropped, front_pushes);
    if (mismatch_count == 0 && results_due == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
